@@ rtl/mpss_pkg.sv @@
// Shared types and constants for the minimum positive run sum unit.
package mpss_pkg;

  localparam int PREFIX_WIDTH = 25;
  localparam int OUT_WIDTH    = 25;
  localparam int OUT_TDATA_W  = 32;

  typedef logic signed [PREFIX_WIDTH-1:0] prefix_t;
  typedef logic [OUT_WIDTH-1:0] sum_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  typedef struct packed {
    logic    start;
    prefix_t prefix;
    logic    entry_valid;
    prefix_t entry;
  } search_cmd_t;

endpackage

@@ rtl/mpss_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module mpss_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mpss_search.sv @@
// Predecessor search: tracks the largest prior prefix strictly below the current one.
module mpss_search (
  input  logic                 clk,
  input  logic                 rst,
  input  mpss_pkg::search_cmd_t cmd,
  output logic                 have_pred,
  output mpss_pkg::prefix_t    pred
);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_pred <= 1'b0;
      pred      <= '0;
    end else if (cmd.start) begin
      have_pred <= (cmd.prefix > mpss_pkg::prefix_t'(0));
      pred      <= '0;
    end else if (cmd.entry_valid && (cmd.entry < cmd.prefix) &&
                 (!have_pred || (cmd.entry > pred))) begin
      have_pred <= 1'b1;
      pred      <= cmd.entry;
    end
  end

endmodule

@@ rtl/min_positive_subarray_sum_unit.sv @@
// Top level of the minimum positive run sum unit.
//
// Input stream s_axis carries one signed sample per request in tdata and
// the end-of-sequence mark in tlast. Output stream m_axis returns one result
// per request: least positive run sum, found flag and overflow flag in tdata,
// and the echoed end mark in tlast.
// Each request adds its sample to a running prefix, then reads every stored
// prefix from the prefix RAM one per cycle through a single comparator, and
// writes the new prefix back. The next request is taken only once the
// result of the last one has been registered, so the unit handles one
// request at a time; the scan reads the RAM through its registered port.
// Once STORE_DEPTH prefixes are stored, no more are kept and the overflow
// flag rises. A request with tlast set clears all state after its result.
// Reset clears the running prefix, the fill count, the found and overflow
// flags and the output valid; the RAM needs no clearing since only filled
// entries are read. The result sits in an output register; if the receiver
// stalls, a finished item waits there and the next item stalls in its final cycle.
module min_positive_subarray_sum_unit #(
  parameter int STORE_DEPTH  = 256,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [SAMPLE_WIDTH-1:0] sample, upper bits zero
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [24:0] best_sum, [25] found, [26] overflowed, [31:27] zero
  output logic [mpss_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tlast
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int PW = mpss_pkg::PREFIX_WIDTH;
  localparam int PADW = mpss_pkg::OUT_TDATA_W - mpss_pkg::OUT_WIDTH - 2;

  mpss_pkg::state_t state;

  mpss_pkg::prefix_t running_prefix;
  logic [CW-1:0]     stored_count;
  mpss_pkg::sum_t    least_positive;
  logic              have_positive;
  logic              overflow_flag;
  logic              last_flag;

  logic [CW-1:0]     rd_idx;
  logic              rd_valid;
  logic              rd_issue;

  logic signed [SAMPLE_WIDTH-1:0] sample;
  mpss_pkg::prefix_t prefix_next;
  logic              in_fire;

  logic [PW-1:0]     ram_rdata;
  logic              store_full;

  mpss_pkg::search_cmd_t cmd;
  logic              have_pred;
  mpss_pkg::prefix_t pred;

  logic signed [PW:0] diff;
  mpss_pkg::sum_t    diff_sum;
  logic              better;
  mpss_pkg::sum_t    least_next;
  logic              have_next;
  logic              overflow_next;
  logic              out_free;
  logic              finish_go;

  assign sample        = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign prefix_next   = running_prefix + PW'(sample);
  assign s_axis_tready = (state == mpss_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign rd_issue   = (state == mpss_pkg::ST_SCAN) && (rd_idx != stored_count);
  assign store_full = (stored_count == CW'(STORE_DEPTH));

  assign cmd.start       = in_fire;
  assign cmd.prefix      = in_fire ? prefix_next : running_prefix;
  assign cmd.entry_valid = rd_valid;
  assign cmd.entry       = mpss_pkg::prefix_t'(ram_rdata);

  mpss_ram #(
    .WIDTH(PW),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (finish_go && !store_full),
    .waddr(stored_count[AW-1:0]),
    .wdata(running_prefix),
    .re   (rd_issue),
    .raddr(rd_idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  mpss_search u_search (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .have_pred(have_pred),
    .pred     (pred)
  );

  assign diff          = {running_prefix[PW-1], running_prefix} - {pred[PW-1], pred};
  assign diff_sum      = diff[PW-1:0];
  assign better        = have_pred && (!have_positive || (diff_sum < least_positive));
  assign least_next    = better ? diff_sum : least_positive;
  assign have_next     = have_positive || have_pred;
  assign overflow_next = overflow_flag || store_full;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign finish_go     = (state == mpss_pkg::ST_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= mpss_pkg::ST_IDLE;
      running_prefix <= '0;
      stored_count   <= '0;
      least_positive <= '0;
      have_positive  <= 1'b0;
      overflow_flag  <= 1'b0;
      rd_idx         <= '0;
      rd_valid       <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      rd_valid <= rd_issue;
      if (rd_issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (finish_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        mpss_pkg::ST_IDLE: begin
          if (in_fire) begin
            running_prefix <= prefix_next;
            rd_idx         <= '0;
            state          <= mpss_pkg::ST_SCAN;
          end
        end
        mpss_pkg::ST_SCAN: begin
          if (!rd_issue && !rd_valid) begin
            state <= mpss_pkg::ST_FINISH;
          end
        end
        mpss_pkg::ST_FINISH: begin
          if (out_free) begin
            state <= mpss_pkg::ST_IDLE;
            if (last_flag) begin
              running_prefix <= '0;
              stored_count   <= '0;
              least_positive <= '0;
              have_positive  <= 1'b0;
              overflow_flag  <= 1'b0;
            end else begin
              least_positive <= least_next;
              have_positive  <= have_next;
              overflow_flag  <= overflow_next;
              if (!store_full) begin
                stored_count <= stored_count + CW'(1);
              end
            end
          end
        end
        default: begin
          state <= mpss_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      last_flag <= s_axis_tlast;
    end
    if (finish_go) begin
      m_axis_tdata <= {PADW'(0), overflow_next, have_next,
                       have_next ? least_next : mpss_pkg::sum_t'(0)};
      m_axis_tlast <= last_flag;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == mpss_pkg::ST_SCAN))
    else $error("read data returned outside scan");

  assert property (@(posedge clk) disable iff (rst)
    stored_count <= CW'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == mpss_pkg::ST_SCAN) && (rd_idx == '0))
    else $error("accepted request did not start a scan");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[mpss_pkg::OUT_WIDTH]) |->
      (m_axis_tdata[mpss_pkg::OUT_WIDTH-1:0] == '0))
    else $error("nonzero sum without found flag");

endmodule
